FILE: hdl/gtwrb_pkg.sv
// ----------------------------------------------------------------------------
// gtwrb_pkg
// shared types, constants and saturating helpers for the greedy route builder
// ----------------------------------------------------------------------------
package gtwrb_pkg;

	localparam int MAX_ROUTES = 1024;
	localparam int COUNT_W    = 11;
	localparam logic [COUNT_W-1:0] COUNT_LIM =
		COUNT_W'((MAX_ROUTES < 2047) ? MAX_ROUTES : 2047);

	localparam logic [15:0] CAP_RESET   = 16'd200;
	localparam logic [23:0] CLOSE_RESET = 24'hFFFFFF;

	localparam logic REG_CAPACITY    = 1'b0;
	localparam logic REG_DEPOT_CLOSE = 1'b1;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// open route as held in the running state
	typedef struct packed {
		logic [31:0] travel;
		logic [23:0] ret;
		logic [31:0] waiting;
		logic [15:0] load;
	} route_t;

	// closed route after the return leg and unbalance are worked out
	typedef struct packed {
		logic [31:0] travel;
		logic [31:0] waiting;
		logic [15:0] load;
		logic [15:0] unbal;
	} closed_t;

	typedef struct packed {
		logic [31:0]        route_distance;
		logic [31:0]        route_waiting;
		logic [15:0]        route_load;
		logic [COUNT_W-1:0] route_number;
		logic [39:0]        sum_distance;
		logic [39:0]        sum_waiting;
		logic [25:0]        sum_unbalance;
		logic               final_route;
	} result_t;

	function automatic logic [31:0] sat32(input logic [34:0] v);
		sat32 = (|v[34:32]) ? 32'hFFFFFFFF : v[31:0];
	endfunction

	function automatic logic [39:0] sat40(input logic [41:0] v);
		sat40 = (|v[41:40]) ? 40'hFFFFFFFFFF : v[39:0];
	endfunction

	function automatic logic [25:0] sat26(input logic [27:0] v);
		sat26 = (|v[27:26]) ? 26'h3FFFFFF : v[25:0];
	endfunction

endpackage

FILE: hdl/greedy_time_window_route_builder.sv
// ----------------------------------------------------------------------------
// greedy_time_window_route_builder
// greedy route construction over a stream of customers with time windows
// ----------------------------------------------------------------------------
// Customers come in on the in_ channel in visiting order, one word per
// customer. A customer joins the open route when load, its due time and the
// depot close time allow; otherwise the open route is closed and reported and
// a new one opens with it. A customer marked last also closes its route.
// Each closed route leaves as one word on the out_ channel, so a customer
// gives zero, one or two result words.
// Throughput: one customer per cycle; the out_ channel moves one word per
// cycle, so customers giving two words are held back once the queue fills.
// Each customer passes the input register and the route update and the return
// leg and unbalance registers; its result words take the running totals as
// they are written into a 16-word queue, where they wait to be offered.
// in_ready is granted while the queue has room for two words for every
// customer in flight plus the new one, so a stalled receiver only holds
// back input once that room is used up; nothing is dropped.
// Configuration writes through cfg_write/cfg_index/cfg_data are taken at once
// and are meant for idle periods. Reset empties the pipeline and queue,
// closes any open route, clears totals and route count, and sets capacity
// to 200 and the depot close time to its maximum.
// ----------------------------------------------------------------------------
module greedy_time_window_route_builder import gtwrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        demand,
	input  logic [23:0]        ready_time,
	input  logic [23:0]        due_time,
	input  logic [23:0]        service_time,
	input  logic [23:0]        dist_from_prev,
	input  logic [23:0]        dist_from_depot,
	input  logic [23:0]        dist_to_depot,
	input  logic               last_customer,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        route_distance,
	output logic [31:0]        route_waiting,
	output logic [15:0]        route_load,
	output logic [COUNT_W-1:0] route_number,
	output logic [39:0]        sum_distance,
	output logic [39:0]        sum_waiting,
	output logic [25:0]        sum_unbalance,
	output logic               final_route
);

	// configuration
	logic [15:0] cap_q;
	logic [23:0] close_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			close_q <= CLOSE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CAPACITY:    cap_q   <= cfg_data[15:0];
				REG_DEPOT_CLOSE: close_q <= cfg_data;
				default:         cap_q   <= cap_q;
			endcase
		end
	end

	// input register
	logic        in_acc;
	logic        v_s1;
	logic [15:0] demand_s1;
	logic [23:0] ready_s1;
	logic [23:0] due_s1;
	logic [23:0] service_s1;
	logic [23:0] d_prev_s1;
	logic [23:0] d_from_s1;
	logic [23:0] d_to_s1;
	logic        last_s1;

	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			demand_s1  <= demand;
			ready_s1   <= ready_time;
			due_s1     <= due_time;
			service_s1 <= service_time;
			d_prev_s1  <= dist_from_prev;
			d_from_s1  <= dist_from_depot;
			d_to_s1    <= dist_to_depot;
			last_s1    <= last_customer;
		end
	end

	// route update
	logic        route_open_q;
	route_t      route_q;
	logic [31:0] finish_q;

	logic [32:0] arrival;
	logic [32:0] ready33;
	logic [16:0] load_sum;
	logic        early;
	logic [32:0] start_app;
	logic [34:0] home;
	logic        appended;
	logic        close_a;
	logic        early_o;
	logic [23:0] open_start;
	logic [24:0] open_finish;
	route_t      mid;
	logic [31:0] mid_finish;

	always_comb begin
		arrival   = {1'b0, finish_q} + {9'd0, d_prev_s1};
		ready33   = {9'd0, ready_s1};
		load_sum  = {1'b0, route_q.load} + {1'b0, demand_s1};
		early     = arrival < ready33;
		start_app = early ? ready33 : arrival;
		home      = {2'b0, start_app} + {11'd0, service_s1} + {11'd0, d_to_s1};
		appended  = route_open_q
			&& (load_sum <= {1'b0, cap_q})
			&& (arrival <= {9'd0, due_s1})
			&& (home <= {11'd0, close_q});
		close_a   = route_open_q && !appended;

		early_o     = d_from_s1 < ready_s1;
		open_start  = early_o ? ready_s1 : d_from_s1;
		open_finish = {1'b0, open_start} + {1'b0, service_s1};

		if (appended) begin
			mid.waiting = sat32({3'b0, route_q.waiting}
				+ (early ? {2'b0, ready33 - arrival} : 35'd0));
			mid.travel  = sat32({3'b0, route_q.travel} + {11'd0, d_prev_s1});
			mid.load    = load_sum[15:0];
			mid.ret     = d_to_s1;
			mid_finish  = sat32({2'b0, start_app} + {11'd0, service_s1});
		end else begin
			mid.waiting = early_o ? {8'd0, ready_s1 - d_from_s1} : 32'd0;
			mid.travel  = {8'd0, d_from_s1};
			mid.load    = demand_s1;
			mid.ret     = d_to_s1;
			mid_finish  = {7'd0, open_finish};
		end
	end

	logic   v_s2;
	logic   has_a_s2;
	logic   has_b_s2;
	route_t a_s2;
	route_t b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			route_open_q <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			if (v_s1) begin
				route_open_q <= !last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			route_q  <= mid;
			finish_q <= mid_finish;
			has_a_s2 <= close_a;
			has_b_s2 <= last_s1;
			a_s2     <= route_q;
			b_s2     <= mid;
		end
	end

	// return leg and unbalance
	closed_t ca;
	closed_t cb;

	always_comb begin
		ca.travel  = sat32({3'b0, a_s2.travel} + {11'd0, a_s2.ret});
		ca.waiting = a_s2.waiting;
		ca.load    = a_s2.load;
		ca.unbal   = (cap_q > a_s2.load) ? cap_q - a_s2.load : 16'd0;
		cb.travel  = sat32({3'b0, b_s2.travel} + {11'd0, b_s2.ret});
		cb.waiting = b_s2.waiting;
		cb.load    = b_s2.load;
		cb.unbal   = (cap_q > b_s2.load) ? cap_q - b_s2.load : 16'd0;
	end

	logic    v_s3;
	logic    has_a_s3;
	logic    has_b_s3;
	closed_t ca_s3;
	closed_t cb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			has_a_s3 <= has_a_s2;
			has_b_s3 <= has_b_s2;
			ca_s3    <= ca;
			cb_s3    <= cb;
		end
	end

	// running totals
	logic [39:0]        tot_dist_q;
	logic [39:0]        tot_wait_q;
	logic [25:0]        tot_unbal_q;
	logic [COUNT_W-1:0] count_q;

	logic [31:0]        da;
	logic [31:0]        wa;
	logic [15:0]        ua;
	logic [39:0]        t1d;
	logic [39:0]        t2d;
	logic [39:0]        t1w;
	logic [39:0]        t2w;
	logic [25:0]        t1u;
	logic [25:0]        t2u;
	logic [COUNT_W-1:0] c1;
	logic [COUNT_W-1:0] c2;
	result_t            rec_a;
	result_t            rec_b;
	result_t            push0;
	logic [1:0]         push_n;

	always_comb begin
		da  = has_a_s3 ? ca_s3.travel : 32'd0;
		wa  = has_a_s3 ? ca_s3.waiting : 32'd0;
		ua  = has_a_s3 ? ca_s3.unbal : 16'd0;
		t1d = sat40({2'b0, tot_dist_q} + {10'd0, da});
		t2d = sat40({2'b0, tot_dist_q} + {10'd0, da} + {10'd0, cb_s3.travel});
		t1w = sat40({2'b0, tot_wait_q} + {10'd0, wa});
		t2w = sat40({2'b0, tot_wait_q} + {10'd0, wa} + {10'd0, cb_s3.waiting});
		t1u = sat26({2'b0, tot_unbal_q} + {12'd0, ua});
		t2u = sat26({2'b0, tot_unbal_q} + {12'd0, ua} + {12'd0, cb_s3.unbal});
		c1  = (has_a_s3 && (count_q < COUNT_LIM)) ? count_q + COUNT_W'(1) : count_q;
		c2  = (c1 < COUNT_LIM) ? c1 + COUNT_W'(1) : c1;

		rec_a.route_distance = ca_s3.travel;
		rec_a.route_waiting  = ca_s3.waiting;
		rec_a.route_load     = ca_s3.load;
		rec_a.route_number   = c1;
		rec_a.sum_distance   = t1d;
		rec_a.sum_waiting    = t1w;
		rec_a.sum_unbalance  = t1u;
		rec_a.final_route    = 1'b0;

		rec_b.route_distance = cb_s3.travel;
		rec_b.route_waiting  = cb_s3.waiting;
		rec_b.route_load     = cb_s3.load;
		rec_b.route_number   = c2;
		rec_b.sum_distance   = t2d;
		rec_b.sum_waiting    = t2w;
		rec_b.sum_unbalance  = t2u;
		rec_b.final_route    = 1'b1;

		push0  = has_a_s3 ? rec_a : rec_b;
		push_n = v_s3 ? {1'b0, has_a_s3} + {1'b0, has_b_s3} : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_dist_q  <= '0;
			tot_wait_q  <= '0;
			tot_unbal_q <= '0;
			count_q     <= '0;
		end else if (v_s3) begin
			priority if (has_b_s3) begin
				tot_dist_q  <= '0;
				tot_wait_q  <= '0;
				tot_unbal_q <= '0;
				count_q     <= '0;
			end else if (has_a_s3) begin
				tot_dist_q  <= t1d;
				tot_wait_q  <= t1w;
				tot_unbal_q <= t1u;
				count_q     <= c1;
			end
		end
	end

	// result queue
	result_t            head;
	logic [FIFO_CW-1:0] fifo_count;
	logic [FIFO_CW+1:0] reserved;

	gtwrb_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_data0 (push0),
		.push_data1 (rec_b),
		.pop        (out_valid && out_ready),
		.head       (head),
		.count      (fifo_count)
	);

	assign reserved = {2'b0, fifo_count}
		+ (FIFO_CW+2)'({v_s1, 1'b0})
		+ (FIFO_CW+2)'({v_s2, 1'b0})
		+ (FIFO_CW+2)'({v_s3, 1'b0});
	assign in_ready = reserved <= (FIFO_CW+2)'(FIFO_DEPTH - 2);

	assign out_valid      = fifo_count != '0;
	assign route_distance = head.route_distance;
	assign route_waiting  = head.route_waiting;
	assign route_load     = head.route_load;
	assign route_number   = head.route_number;
	assign sum_distance   = head.sum_distance;
	assign sum_waiting    = head.sum_waiting;
	assign sum_unbalance  = head.sum_unbalance;
	assign final_route    = head.final_route;

endmodule

FILE: hdl/gtwrb_result_fifo.sv
// ----------------------------------------------------------------------------
// gtwrb_result_fifo
// result queue taking up to two words a cycle and giving one
// ----------------------------------------------------------------------------
module gtwrb_result_fifo import gtwrb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  result_t             push_data0,
	input  result_t             push_data1,
	input  logic                pop,
	output result_t             head,
	output logic [FIFO_CW-1:0]  count
);

	result_t            mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic [FIFO_AW-1:0] wr_next;

	assign wr_next = wr_ptr_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_ptr_q] <= push_data0;
		end
		if (push_n == 2'd2) begin
			mem[wr_next] <= push_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	assign head  = mem[rd_ptr_q];
	assign count = count_q;

endmodule

FILE: test/greedy_time_window_route_builder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_time_window_route_builder_checker
// Watches the register port and the customer and route channels. Every
// accepted customer runs through a local copy of the route state. The routes
// it closes are queued and then compared, field by field, with the route
// words that the block returns.
// ----------------------------------------------------------------------------
module greedy_time_window_route_builder_checker import gtwrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [15:0]        demand,
	input  logic [23:0]        ready_time,
	input  logic [23:0]        due_time,
	input  logic [23:0]        service_time,
	input  logic [23:0]        dist_from_prev,
	input  logic [23:0]        dist_from_depot,
	input  logic [23:0]        dist_to_depot,
	input  logic               last_customer,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [31:0]        route_distance,
	input  logic [31:0]        route_waiting,
	input  logic [15:0]        route_load,
	input  logic [COUNT_W-1:0] route_number,
	input  logic [39:0]        sum_distance,
	input  logic [39:0]        sum_waiting,
	input  logic [25:0]        sum_unbalance,
	input  logic               final_route,
	output int                 fail_count,
	output int                 routes_pending
);

	localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;
	localparam logic [63:0] SAT40 = 64'hFF_FFFF_FFFF;
	localparam logic [63:0] SAT26 = 64'h3FF_FFFF;
	localparam logic [COUNT_W-1:0] ROUTE_LIMIT =
		COUNT_W'((MAX_ROUTES < 2047) ? MAX_ROUTES : 2047);

	logic [15:0]        capacity;
	logic [23:0]        close_time;
	logic               route_open;
	logic [16:0]        load_acc;
	logic [31:0]        finish_at;
	logic [31:0]        dist_acc;
	logic [31:0]        wait_acc;
	logic [23:0]        home_dist;
	logic [39:0]        total_dist;
	logic [39:0]        total_wait;
	logic [26:0]        total_spare;
	logic [COUNT_W-1:0] closed_routes;

	result_t closed_q[$];
	result_t oldest;
	int      mismatches = 0;
	int      queued = 0;

	assign fail_count     = mismatches;
	assign routes_pending = queued;

	function automatic logic [63:0] capped(input logic [63:0] v, input logic [63:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	task automatic check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t %s expected %0h got %0h", $time, label, want, got);
			mismatches++;
		end
	endtask

	task automatic close_route(input logic last_route);
		result_t     r;
		logic [31:0] trip;
		logic [15:0] spare;
		trip = 32'(capped(64'(dist_acc) + 64'(home_dist), SAT32));
		spare = (17'(capacity) > load_acc) ? capacity - load_acc[15:0] : 16'd0;
		total_dist = 40'(capped(64'(total_dist) + 64'(trip), SAT40));
		total_wait = 40'(capped(64'(total_wait) + 64'(wait_acc), SAT40));
		total_spare = 27'(capped(64'(total_spare) + 64'(spare), SAT26));
		if (closed_routes < ROUTE_LIMIT)
			closed_routes++;
		r.route_distance = trip;
		r.route_waiting  = wait_acc;
		r.route_load     = load_acc[15:0];
		r.route_number   = closed_routes;
		r.sum_distance   = total_dist;
		r.sum_waiting    = total_wait;
		r.sum_unbalance  = total_spare[25:0];
		r.final_route    = last_route;
		closed_q.insert(closed_q.size(), r);
		route_open = 1'b0;
		load_acc   = '0;
		finish_at  = '0;
		dist_acc   = '0;
		wait_acc   = '0;
		home_dist  = '0;
	endtask

	task automatic take_customer();
		logic [63:0] arrival;
		logic [63:0] start;
		logic        joined;
		joined = 1'b0;
		if (route_open) begin
			arrival = 64'(finish_at) + 64'(dist_from_prev);
			if (64'(load_acc) + 64'(demand) <= 64'(capacity) && arrival <= 64'(due_time)) begin
				start = (arrival < 64'(ready_time)) ? 64'(ready_time) : arrival;
				if (start + 64'(service_time) + 64'(dist_to_depot) <= 64'(close_time)) begin
					if (arrival < 64'(ready_time))
						wait_acc = 32'(capped(64'(wait_acc) + (64'(ready_time) - arrival), SAT32));
					dist_acc  = 32'(capped(64'(dist_acc) + 64'(dist_from_prev), SAT32));
					finish_at = 32'(capped(start + 64'(service_time), SAT32));
					load_acc  = load_acc + 17'(demand);
					home_dist = dist_to_depot;
					joined = 1'b1;
				end
			end
			if (!joined)
				close_route(1'b0);
		end
		if (!joined) begin
			route_open = 1'b1;
			if (dist_from_depot < ready_time) begin
				wait_acc = 32'(ready_time - dist_from_depot);
				start = 64'(ready_time);
			end else begin
				wait_acc = '0;
				start = 64'(dist_from_depot);
			end
			finish_at = 32'(capped(start + 64'(service_time), SAT32));
			load_acc  = 17'(demand);
			dist_acc  = 32'(dist_from_depot);
			home_dist = dist_to_depot;
		end
		if (last_customer) begin
			close_route(1'b1);
			total_dist    = '0;
			total_wait    = '0;
			total_spare   = '0;
			closed_routes = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity      = CAP_RESET;
			close_time    = CLOSE_RESET;
			route_open    = 1'b0;
			load_acc      = '0;
			finish_at     = '0;
			dist_acc      = '0;
			wait_acc      = '0;
			home_dist     = '0;
			total_dist    = '0;
			total_wait    = '0;
			total_spare   = '0;
			closed_routes = '0;
			closed_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (closed_q.size() == 0) begin
					$display("%0t route word with none expected: distance %0h load %0h",
						$time, route_distance, route_load);
					mismatches++;
				end else begin
					oldest = closed_q.pop_front();
					check_field("route_distance", 64'(oldest.route_distance),
						64'(route_distance));
					check_field("route_waiting", 64'(oldest.route_waiting),
						64'(route_waiting));
					check_field("route_load", 64'(oldest.route_load), 64'(route_load));
					check_field("route_number", 64'(oldest.route_number),
						64'(route_number));
					check_field("sum_distance", 64'(oldest.sum_distance), 64'(sum_distance));
					check_field("sum_waiting", 64'(oldest.sum_waiting), 64'(sum_waiting));
					check_field("sum_unbalance", 64'(oldest.sum_unbalance),
						64'(sum_unbalance));
					check_field("final_route", 64'(oldest.final_route), 64'(final_route));
				end
			end
			if (cfg_write) begin
				if (cfg_index == REG_CAPACITY)
					capacity = cfg_data[15:0];
				else
					close_time = cfg_data;
			end
			if (in_valid && in_ready)
				take_customer();
		end
		queued = closed_q.size();
	end

endmodule

FILE: test/greedy_time_window_route_builder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_time_window_route_builder_tb
// Drives customers into the route builder and gives the verdict. It starts
// with directed customers at the capacity and time limits, then runs random
// phases under changing capacity and depot close settings and changing pacing
// on both channels. One long sequence pushes the route count into saturation.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module greedy_time_window_route_builder_tb import gtwrb_pkg::*; ();

	typedef struct packed {
		logic [15:0] demand;
		logic [23:0] ready_time;
		logic [23:0] due_time;
		logic [23:0] service_time;
		logic [23:0] dist_from_prev;
		logic [23:0] dist_from_depot;
		logic [23:0] dist_to_depot;
		logic        last_customer;
	} customer_t;

	typedef enum int {PACE_FULL, PACE_SLOW_IN, PACE_SLOW_OUT, PACE_BOTH} pacing_t;

	localparam logic [23:0] T_MAX = 24'hFFFFFF;
	localparam logic [15:0] D_MAX = 16'hFFFF;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	logic               cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [15:0]        demand;
	logic [23:0]        ready_time;
	logic [23:0]        due_time;
	logic [23:0]        service_time;
	logic [23:0]        dist_from_prev;
	logic [23:0]        dist_from_depot;
	logic [23:0]        dist_to_depot;
	logic               last_customer;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        route_distance;
	logic [31:0]        route_waiting;
	logic [15:0]        route_load;
	logic [COUNT_W-1:0] route_number;
	logic [39:0]        sum_distance;
	logic [39:0]        sum_waiting;
	logic [25:0]        sum_unbalance;
	logic               final_route;
	int                 fail_count;
	int                 routes_pending;

	int in_gap_pct = 0;
	int out_stall_pct = 0;

	greedy_time_window_route_builder dut (.*);

	greedy_time_window_route_builder_checker route_checker (.*);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
	end

	function automatic customer_t mk_customer(input logic [15:0] dem, input logic [23:0] rdy,
			input logic [23:0] due, input logic [23:0] svc, input logic [23:0] prev,
			input logic [23:0] from_dep, input logic [23:0] to_dep, input logic last);
		customer_t c;
		c.demand          = dem;
		c.ready_time      = rdy;
		c.due_time        = due;
		c.service_time    = svc;
		c.dist_from_prev  = prev;
		c.dist_from_depot = from_dep;
		c.dist_to_depot   = to_dep;
		c.last_customer   = last;
		return c;
	endfunction

	function automatic logic [23:0] wild24();
		case ($urandom_range(0, 3))
			0: return 24'd0;
			1: return T_MAX;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic customer_t random_customer(input bit tidy, input bit may_end);
		customer_t   c;
		logic [23:0] w;
		if (tidy) begin
			c.demand          = 16'($urandom_range(0, 60));
			c.ready_time      = 24'($urandom_range(0, 'h3000));
			c.due_time        = c.ready_time + 24'($urandom_range(0, 'h6000));
			c.service_time    = 24'($urandom_range(0, 'h300));
			c.dist_from_prev  = 24'($urandom_range(0, 'h800));
			c.dist_from_depot = 24'($urandom_range(0, 'h800));
			c.dist_to_depot   = 24'($urandom_range(0, 'h800));
		end else begin
			w = wild24();
			c.demand          = w[15:0];
			c.ready_time      = wild24();
			c.due_time        = wild24();
			c.service_time    = wild24();
			c.dist_from_prev  = wild24();
			c.dist_from_depot = wild24();
			c.dist_to_depot   = wild24();
		end
		c.last_customer = may_end && ($urandom_range(0, 11) == 0);
		return c;
	endfunction

	task automatic set_pacing(input pacing_t mode);
		case (mode)
			PACE_FULL: begin
				in_gap_pct = 0;
				out_stall_pct = 0;
			end
			PACE_SLOW_IN: begin
				in_gap_pct = 87;
				out_stall_pct = 0;
			end
			PACE_SLOW_OUT: begin
				in_gap_pct = 0;
				out_stall_pct = 87;
			end
			default: begin
				in_gap_pct = 15;
				out_stall_pct = 15;
			end
		endcase
	endtask

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_customer(input customer_t c);
		while ($urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		demand          <= c.demand;
		ready_time      <= c.ready_time;
		due_time        <= c.due_time;
		service_time    <= c.service_time;
		dist_from_prev  <= c.dist_from_prev;
		dist_from_depot <= c.dist_from_depot;
		dist_to_depot   <= c.dist_to_depot;
		last_customer   <= c.last_customer;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic reconfigure(input logic [15:0] cap, input logic [23:0] close_at);
		logic [7:0] upper;
		in_valid <= 1'b0;
		while (routes_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		upper = 8'($urandom);
		cfg_write <= 1'b1;
		cfg_index <= REG_CAPACITY;
		cfg_data  <= {upper, cap};
		@(negedge clk);
		cfg_index <= REG_DEPOT_CLOSE;
		cfg_data  <= close_at;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		logic [15:0] cap;
		logic [23:0] close_at;
		customer_t   c;
		arst_n          <= 1'b0;
		cfg_write       <= 1'b0;
		cfg_index       <= REG_CAPACITY;
		cfg_data        <= '0;
		in_valid        <= 1'b0;
		demand          <= '0;
		ready_time      <= '0;
		due_time        <= '0;
		service_time    <= '0;
		dist_from_prev  <= '0;
		dist_from_depot <= '0;
		dist_to_depot   <= '0;
		last_customer   <= 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_pacing(PACE_FULL);
		send_customer(mk_customer(0, 0, 0, 0, 0, 0, 0, 0));
		// first customer above capacity, then its route closes with no spare
		send_customer(mk_customer(D_MAX, 0, T_MAX, 0, 0, 0, 0, 0));
		send_customer(mk_customer(5, 'h100, T_MAX, 'h10, 'h10, 'h100, 'h100, 0));
		send_customer(mk_customer(5, 'h8000, T_MAX, 'h20, 'h40, 0, 'h80, 0));
		send_customer(mk_customer(5, 0, 0, 0, 'h10, 'h20, 'h20, 0));
		send_customer(mk_customer(5, 0, T_MAX, T_MAX, 0, 0, 0, 0));
		send_customer(mk_customer(5, 0, T_MAX, 0, 0, 0, 0, 0));
		// close of the open route and of the last one on a single word
		send_customer(mk_customer(D_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, 1));
		send_customer(mk_customer(1, 'h500, 'h600, 'h10, 'h30, 'h100, 'h200, 1));
		send_customer(mk_customer(200, 0, T_MAX, 0, 0, T_MAX, T_MAX, 0));
		send_customer(mk_customer(0, 0, T_MAX, 0, 0, 0, 0, 0));
		send_customer(mk_customer(1, 0, T_MAX, 0, 0, 0, 0, 0));
		send_customer(mk_customer(0, 0, T_MAX, 0, 0, 0, 0, 1));
		send_customer(mk_customer(D_MAX, 'h40, T_MAX, 'h10, 0, 0, 0, 0));

		reconfigure(D_MAX, 24'd0);
		send_customer(mk_customer(0, 0, 0, 0, 0, 0, 0, 0));
		send_customer(mk_customer(0, 0, 0, 0, 0, 0, 0, 0));
		send_customer(mk_customer(0, 0, T_MAX, 1, 0, 0, 0, 0));
		send_customer(mk_customer(D_MAX, 0, T_MAX, 0, 0, 0, 0, 0));
		send_customer(mk_customer(D_MAX, 0, T_MAX, 0, 0, 0, 0, 1));

		for (int p = 0; p < 12; p++) begin
			case (p)
				0:  begin cap = 16'd200;   close_at = T_MAX;      end
				1:  begin cap = D_MAX;     close_at = 24'd0;      end
				2:  begin cap = 16'd0;     close_at = T_MAX;      end
				3:  begin cap = 16'd100;   close_at = 24'h20000;  end
				5:  begin cap = 16'd40;    close_at = 24'h8000;   end
				6:  begin cap = 16'd1;     close_at = T_MAX;      end
				7:  begin cap = D_MAX;     close_at = 24'h4000;   end
				8:  begin cap = 16'd300;   close_at = 24'h3000;   end
				10: begin cap = 16'd200;   close_at = 24'd0;      end
				11: begin cap = 16'd7;     close_at = 24'h10000;  end
				default: begin
					cap = 16'($urandom);
					close_at = 24'($urandom);
				end
			endcase
			reconfigure(cap, close_at);
			set_pacing(pacing_t'(p % 4));
			for (int i = 0; i < 30; i++)
				send_customer(random_customer($urandom_range(0, 9) < 7, 1'b1));
		end

		// zero capacity: every customer closes a route, so the count saturates
		reconfigure(16'd0, 24'($urandom));
		for (int i = 0; i < 1050; i++) begin
			set_pacing(pacing_t'((i / 150) % 4));
			c = random_customer($urandom_range(0, 9) < 7, 1'b0);
			if (c.demand == 16'd0)
				c.demand = 16'd1;
			send_customer(c);
		end
		c = random_customer(1'b1, 1'b0);
		c.last_customer = 1'b1;
		send_customer(c);

		in_valid <= 1'b0;
		while (routes_pending != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hdl/gtwrb_pkg.sv
hdl/gtwrb_result_fifo.sv
hdl/greedy_time_window_route_builder.sv
test/greedy_time_window_route_builder_checker.sv
test/greedy_time_window_route_builder_tb.sv
